// ----- rtl/srat_pkg.sv -----
package srat_pkg;

  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 24;
  localparam int SEGNUM_W = 8;

  localparam logic [31:0] THRESHOLD_RESET = 32'h0880_0000;

  typedef enum logic [1:0] {
    OP_TRANSLATE,
    OP_RANGE,
    OP_BASE,
    OP_COUNT
  } op_t;

  typedef enum logic [2:0] {
    OUT_ABOVE,
    OUT_SEGRANGE,
    OUT_HIT,
    OUT_BASE,
    OUT_MISS
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEG,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [23:0] range_start;
    logic [24:0] range_length;
    logic [31:0] range_target;
  } entry_t;

endpackage

// ----- rtl/srat_if.sv -----
interface srat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] seg_address;
  logic [3:0]  segment_number;
  logic [5:0]  entry_slot;
  logic [23:0] range_start;
  logic [24:0] range_length;
  logic [31:0] range_target;
  logic [31:0] base_value;
  logic [6:0]  entry_count;

  modport source (
    output valid, op, seg_address, segment_number, entry_slot,
           range_start, range_length, range_target, base_value, entry_count,
    input  ready
  );
  modport sink (
    input  valid, op, seg_address, segment_number, entry_slot,
           range_start, range_length, range_target, base_value, entry_count,
    output ready
  );
endinterface

interface srat_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] flat_address;
  logic [2:0]  outcome;

  modport source (output valid, flat_address, outcome, input ready);
  modport sink   (input valid, flat_address, outcome, output ready);
endinterface

// ----- rtl/srat_range_mem.sv -----
module srat_range_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  srat_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output srat_pkg::entry_t     rdata
);

  srat_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/segment_range_address_translator_top.sv -----
// channel | dir | fields
// --------+-----+---------------------------------------------------------------
// req     | in  | op, seg_address, segment_number, entry_slot, range_start,
//         |     | range_length, range_target, base_value, entry_count
// rsp     | out | flat_address, outcome (one per translate request)
// cfg     | in  | cfg_we, cfg_wdata -> passthrough threshold
//
// One request at a time. A range write is done on acceptance. A base or count
// write is a read-modify-write of the segment table. A passthrough translate
// goes straight to the result; a searched translate reads the segment table and
// then binary-searches the ranges, each probe one range memory read.
// Reset: threshold 0x0880_0000; counts and bases read zero via per-segment
// valid bits; the range memory is not cleared.
// A result waits in the output register; a new request is accepted meanwhile,
// a finished translate holds until that register is free.
module segment_range_address_translator_top #(
  parameter int NUM_SEGMENTS = 16,
  parameter int MAX_RANGES   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  srat_req_if.sink    req,
  srat_rsp_if.source  rsp
);

  localparam int SEG_W   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int SLOT_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W   = $clog2(MAX_RANGES + 1);
  localparam int DEPTH   = NUM_SEGMENTS * MAX_RANGES;
  localparam int MADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int REC_W   = CNT_W + 32;

  srat_pkg::state_t   state, state_next;
  logic [31:0]        threshold;

  srat_pkg::op_t      op_q;
  logic [SEG_W-1:0]   seg_q;
  logic [23:0]        offset_q;
  logic [31:0]        base_val_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [31:0]        base_q;
  logic [CNT_W-1:0]   lo, hiex;
  logic [SLOT_W-1:0]  mid_q;
  logic [31:0]        res_flat;
  srat_pkg::outcome_t res_outcome;

  logic               out_vld;
  logic [31:0]        out_flat;
  srat_pkg::outcome_t out_outcome;

  // segment table: count and base, per-segment valid bits
  logic [REC_W-1:0]   seg_mem [NUM_SEGMENTS];
  logic [NUM_SEGMENTS-1:0] seg_vld;
  logic [REC_W-1:0]   seg_rd;
  logic               seg_rd_vld;
  logic               seg_re, seg_we;
  logic [SEG_W-1:0]   seg_raddr;
  logic [REC_W-1:0]   seg_wdata;

  logic               ent_we, ent_re;
  logic [MADDR_W-1:0] ent_waddr, ent_raddr;
  srat_pkg::entry_t   ent_wdata, ent_rd;

  srat_pkg::op_t      req_op;
  logic               accept, out_free, pass_thru, above;
  logic [7:0]         a_seg8, w_seg8;
  logic [9:0]         slot10;
  logic               wseg_ok, slot_ok;
  logic [CNT_W-1:0]   cnt_sat;
  logic [CNT_W-1:0]   count_cur;
  logic [31:0]        base_cur;
  logic [CNT_W:0]     msum;
  logic [SLOT_W-1:0]  mid;
  logic [31:0]        waddr32, raddr32;
  logic [25:0]        ent_end;
  logic               below, past, hit;
  logic [23:0]        ofs_in_range;

  assign req_op   = srat_pkg::op_t'(req.op);
  assign accept   = req.valid && req.ready;
  assign out_free = !out_vld || rsp.ready;

  assign a_seg8    = req.seg_address[31:24];
  assign w_seg8    = {4'b0, req.segment_number};
  assign slot10    = {4'b0, req.entry_slot};
  assign above     = req.seg_address >= threshold;
  assign pass_thru = above || (32'(a_seg8) >= 32'(NUM_SEGMENTS));
  assign wseg_ok   = 32'(req.segment_number) < 32'(NUM_SEGMENTS);
  assign slot_ok   = 32'(req.entry_slot) < 32'(MAX_RANGES);
  assign cnt_sat   = (32'(req.entry_count) > 32'(MAX_RANGES)) ? CNT_W'(MAX_RANGES)
                                                              : CNT_W'(req.entry_count);

  assign count_cur = seg_rd_vld ? seg_rd[REC_W-1:32] : '0;
  assign base_cur  = seg_rd_vld ? seg_rd[31:0] : '0;

  assign msum = (CNT_W+1)'(lo) + (CNT_W+1)'(hiex) - (CNT_W+1)'(1);
  assign mid  = msum[SLOT_W:1];

  assign waddr32   = 32'(w_seg8[SEG_W-1:0]) * 32'(MAX_RANGES) + 32'(slot10[SLOT_W-1:0]);
  assign raddr32   = 32'(seg_q) * 32'(MAX_RANGES) + 32'(mid);
  assign ent_waddr = waddr32[MADDR_W-1:0];
  assign ent_raddr = raddr32[MADDR_W-1:0];
  assign ent_wdata = '{range_start:  req.range_start,
                       range_length: req.range_length,
                       range_target: req.range_target};

  assign ent_end      = 26'(ent_rd.range_start) + 26'(ent_rd.range_length);
  assign below        = offset_q < ent_rd.range_start;
  assign past         = 26'(offset_q) >= ent_end;
  assign hit          = !below && !past;
  assign ofs_in_range = offset_q - ent_rd.range_start;

  assign seg_raddr = (req_op == srat_pkg::OP_TRANSLATE) ? a_seg8[SEG_W-1:0]
                                                        : w_seg8[SEG_W-1:0];
  assign seg_wdata = (op_q == srat_pkg::OP_BASE) ? {count_cur, base_val_q}
                                                 : {cnt_q, base_cur};

  srat_range_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (MADDR_W)
  ) u_range_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      srat_pkg::S_IDLE: begin
        if (accept) begin
          case (req_op)
            srat_pkg::OP_TRANSLATE: state_next = pass_thru ? srat_pkg::S_DONE
                                                           : srat_pkg::S_SEG;
            srat_pkg::OP_RANGE:     state_next = srat_pkg::S_IDLE;
            default:                state_next = wseg_ok ? srat_pkg::S_SEG
                                                         : srat_pkg::S_IDLE;
          endcase
        end
      end
      srat_pkg::S_SEG: begin
        if (op_q != srat_pkg::OP_TRANSLATE) begin
          state_next = srat_pkg::S_IDLE;
        end else if (count_cur == '0) begin
          state_next = srat_pkg::S_DONE;
        end else begin
          state_next = srat_pkg::S_PROBE;
        end
      end
      srat_pkg::S_PROBE: state_next = (lo < hiex) ? srat_pkg::S_CMP : srat_pkg::S_DONE;
      srat_pkg::S_CMP:   state_next = hit ? srat_pkg::S_DONE : srat_pkg::S_PROBE;
      srat_pkg::S_DONE:  state_next = out_free ? srat_pkg::S_IDLE : srat_pkg::S_DONE;
      default:           state_next = srat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    seg_re    = 1'b0;
    seg_we    = 1'b0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    case (state)
      srat_pkg::S_IDLE: begin
        req.ready = 1'b1;
        seg_re    = accept;
        ent_we    = accept && (req_op == srat_pkg::OP_RANGE) && wseg_ok && slot_ok;
      end
      srat_pkg::S_SEG:   seg_we = (op_q != srat_pkg::OP_TRANSLATE);
      srat_pkg::S_PROBE: ent_re = (lo < hiex);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srat_pkg::S_IDLE;
      threshold <= srat_pkg::THRESHOLD_RESET;
      seg_vld   <= '0;
      out_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (seg_we) begin
        seg_vld[seg_q] <= 1'b1;
      end
      if (state == srat_pkg::S_DONE && out_free) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg_re) begin
      seg_rd     <= seg_mem[seg_raddr];
      seg_rd_vld <= seg_vld[seg_raddr];
    end
    if (seg_we) begin
      seg_mem[seg_q] <= seg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      srat_pkg::S_IDLE: begin
        if (accept) begin
          op_q       <= req_op;
          seg_q      <= seg_raddr;
          offset_q   <= req.seg_address[23:0];
          base_val_q <= req.base_value;
          cnt_q      <= cnt_sat;
          res_flat   <= req.seg_address;
          res_outcome <= above ? srat_pkg::OUT_ABOVE : srat_pkg::OUT_SEGRANGE;
        end
      end
      srat_pkg::S_SEG: begin
        base_q      <= base_cur;
        lo          <= '0;
        hiex        <= count_cur;
        res_flat    <= base_cur + 32'(offset_q);
        res_outcome <= srat_pkg::OUT_BASE;
      end
      srat_pkg::S_PROBE: begin
        mid_q <= mid;
        if (lo >= hiex) begin
          if (base_q == '0) begin
            res_flat    <= '0;
            res_outcome <= srat_pkg::OUT_MISS;
          end else begin
            res_flat    <= base_q + 32'(offset_q);
            res_outcome <= srat_pkg::OUT_BASE;
          end
        end
      end
      srat_pkg::S_CMP: begin
        if (hit) begin
          res_flat    <= ent_rd.range_target + 32'(ofs_in_range);
          res_outcome <= srat_pkg::OUT_HIT;
        end else if (below) begin
          hiex <= CNT_W'(mid_q);
        end else begin
          lo <= CNT_W'(mid_q) + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (state == srat_pkg::S_DONE && out_free) begin
      out_flat    <= res_flat;
      out_outcome <= res_outcome;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.flat_address = out_flat;
  assign rsp.outcome      = out_outcome;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (state != srat_pkg::S_IDLE) |-> !req.ready)
    else $error("request taken while busy");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == srat_pkg::S_PROBE) |-> (lo <= hiex))
    else $error("search window inverted");

  a_miss_null: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.outcome == srat_pkg::OUT_MISS) |-> (rsp.flat_address == '0))
    else $error("miss with non-null address");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == srat_pkg::S_DONE && out_free) |=> rsp.valid)
    else $error("finished translate not presented");

endmodule
